[sv/ibd_pkg.sv]
// ibd_pkg: constants, derived widths and controller/datapath interface types
// for the serial frame decoder. No dependencies.
`timescale 1ns / 1ps

package ibd_pkg;

  localparam int NUM_CHANNELS = 14;
  localparam int FRAME_BYTES  = 32;

  localparam int PAIRS_IN_FRAME = (FRAME_BYTES - 4) / 2;
  localparam int EMIT_COUNT = (PAIRS_IN_FRAME < NUM_CHANNELS) ? PAIRS_IN_FRAME : NUM_CHANNELS;

  localparam int BYTE_W     = 8;
  localparam int VALUE_W    = 16;
  localparam int CHAN_IDX_W = 4;
  localparam int POS_W      = $clog2(FRAME_BYTES);
  localparam int CH_W       = (EMIT_COUNT > 1) ? $clog2(EMIT_COUNT) : 1;

  localparam logic [BYTE_W-1:0]  HDR0     = 8'h20;
  localparam logic [BYTE_W-1:0]  HDR1     = 8'h40;
  localparam logic [VALUE_W-1:0] SUM_INIT = 16'hFFFF;

  // Controller to datapath
  typedef struct packed {
    logic sum_hdr0;    // first header byte seen: restart the sum
    logic hdr1_ok;     // second header byte seen: subtract it, start body count
    logic body;        // body byte: subtract, hold or store, advance position
    logic ck_lo;       // low checksum byte: hold it
    logic emit_start;  // good frame: point output at channel zero
    logic emit_adv;    // output transfer: step to next channel
  } ibd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_hdr0;
    logic is_hdr1;
    logic body_end;    // current body byte is the last one before the checksum
    logic sum_ok;      // received checksum equals running sum
    logic emit_last;   // output is on the final channel
  } ibd_status_t;

endpackage

[sv/ibd_ctrl.sv]
// ibd_ctrl: frame state machine of the decoder (hunt, header, body,
// checksum, drain). Depends on ibd_pkg.
`timescale 1ns / 1ps

module ibd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_stall,
  input  ibd_pkg::ibd_status_t status,
  output ibd_pkg::ibd_cmd_t    cmd,
  output logic                 in_stall,
  output logic                 out_valid
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HDR,
    ST_BODY,
    ST_CK_LO,
    ST_CK_HI,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   give;

  assign in_stall  = out_valid_r;
  assign out_valid = out_valid_r;
  assign take      = in_valid && !out_valid_r;
  assign give      = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      ST_HUNT: begin
        if (take && status.is_hdr0) begin
          cmd.sum_hdr0 = 1'b1;
          state_nxt    = ST_HDR;
        end
      end
      ST_HDR: begin
        if (take) begin
          if (status.is_hdr1) begin
            cmd.hdr1_ok = 1'b1;
            state_nxt   = ST_BODY;
          end else if (status.is_hdr0) begin
            cmd.sum_hdr0 = 1'b1;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_BODY: begin
        if (take) begin
          cmd.body = 1'b1;
          if (status.body_end) begin
            state_nxt = ST_CK_LO;
          end
        end
      end
      ST_CK_LO: begin
        if (take) begin
          cmd.ck_lo = 1'b1;
          state_nxt = ST_CK_HI;
        end
      end
      ST_CK_HI: begin
        if (take) begin
          if (status.sum_ok) begin
            cmd.emit_start = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_EMIT;
          end else begin
            // bad checksum: drop the frame
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (give) begin
          cmd.emit_adv = 1'b1;
          if (status.emit_last) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt     = ST_HUNT;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/ibd_datapath.sv]
// ibd_datapath: running checksum, byte position, low-byte hold, channel
// store and output selection. Depends on ibd_pkg.
`timescale 1ns / 1ps

module ibd_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [ibd_pkg::BYTE_W-1:0]           in_rx_byte,
  input  ibd_pkg::ibd_cmd_t                    cmd,
  output ibd_pkg::ibd_status_t                 status,
  output logic [ibd_pkg::CHAN_IDX_W-1:0]       out_channel_index,
  output logic [ibd_pkg::VALUE_W-1:0]          out_channel_value,
  output logic                                 out_last
);

  logic [ibd_pkg::VALUE_W-1:0] sum_r, sum_nxt;
  logic [ibd_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [ibd_pkg::BYTE_W-1:0]  hold_r, hold_nxt;
  logic [ibd_pkg::CH_W-1:0]    emit_idx_r, emit_idx_nxt;
  logic [ibd_pkg::VALUE_W-1:0] store_r [ibd_pkg::EMIT_COUNT];

  logic [ibd_pkg::POS_W-1:0]   pos_m2;
  logic [ibd_pkg::POS_W-2:0]   ch;
  logic                        store_wr;

  assign pos_m2   = pos_r - ibd_pkg::POS_W'(2);
  assign ch       = pos_m2[ibd_pkg::POS_W-1:1];
  assign store_wr = cmd.body && pos_r[0] && (int'(ch) < ibd_pkg::EMIT_COUNT);

  assign status.is_hdr0   = (in_rx_byte == ibd_pkg::HDR0);
  assign status.is_hdr1   = (in_rx_byte == ibd_pkg::HDR1);
  assign status.body_end  = (pos_r == ibd_pkg::POS_W'(ibd_pkg::FRAME_BYTES - 3));
  assign status.sum_ok    = ({in_rx_byte, hold_r} == sum_r);
  assign status.emit_last = (emit_idx_r == ibd_pkg::CH_W'(ibd_pkg::EMIT_COUNT - 1));

  always_comb begin
    sum_nxt      = sum_r;
    pos_nxt      = pos_r;
    hold_nxt     = hold_r;
    emit_idx_nxt = emit_idx_r;
    if (cmd.sum_hdr0) begin
      sum_nxt = ibd_pkg::SUM_INIT - ibd_pkg::VALUE_W'(ibd_pkg::HDR0);
    end
    if (cmd.hdr1_ok) begin
      sum_nxt = sum_r - ibd_pkg::VALUE_W'(in_rx_byte);
      pos_nxt = ibd_pkg::POS_W'(2);
    end
    if (cmd.body) begin
      sum_nxt = sum_r - ibd_pkg::VALUE_W'(in_rx_byte);
      pos_nxt = pos_r + ibd_pkg::POS_W'(1);
      if (!pos_r[0]) begin
        hold_nxt = in_rx_byte;
      end
    end
    if (cmd.ck_lo) begin
      hold_nxt = in_rx_byte;
    end
    if (cmd.emit_start) begin
      emit_idx_nxt = '0;
    end
    if (cmd.emit_adv && !status.emit_last) begin
      emit_idx_nxt = emit_idx_r + ibd_pkg::CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= ibd_pkg::SUM_INIT;
      pos_r      <= '0;
      hold_r     <= '0;
      emit_idx_r <= '0;
    end else begin
      sum_r      <= sum_nxt;
      pos_r      <= pos_nxt;
      hold_r     <= hold_nxt;
      emit_idx_r <= emit_idx_nxt;
    end
  end

  // Channel store: no reset, every entry is written before it is drained
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[ch[ibd_pkg::CH_W-1:0]] <= {in_rx_byte, hold_r};
    end
  end

  assign out_channel_index = ibd_pkg::CHAN_IDX_W'(emit_idx_r);
  assign out_channel_value = store_r[emit_idx_r];
  assign out_last          = status.emit_last;

endmodule

[sv/ibus_frame_decoder.sv]
// ibus_frame_decoder: top level of the serial frame decoder; joins the
// controller and the datapath. Depends on ibd_pkg, ibd_ctrl, ibd_datapath.
`timescale 1ns / 1ps
//
//   channel | direction | ports                                         | transfer
//   in      | input     | in_valid, in_stall, in_rx_byte                | valid && !stall
//   out     | output    | out_valid, out_stall, out_channel_index,      | valid && !stall
//           |           | out_channel_value, out_last                   |
//
// Bytes are taken one per cycle outside a drain. A frame whose checksum matches is then
// drained as EMIT_COUNT results, one per cycle; the single read of the
// channel store per cycle sets that pace, and in_stall stays high until the
// last channel is transferred. Output stalls stretch the drain cycle for cycle.
// Synchronous active-low reset returns to header hunting; no clearing pass.

module ibus_frame_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ibd_pkg::BYTE_W-1:0]           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ibd_pkg::CHAN_IDX_W-1:0]       out_channel_index,
  output logic [ibd_pkg::VALUE_W-1:0]          out_channel_value,
  output logic                                 out_last
);

  ibd_pkg::ibd_cmd_t    cmd;
  ibd_pkg::ibd_status_t status;

  ibd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  ibd_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .status            (status),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last          (out_last)
  );

  // No byte is taken while a frame drains
  a_no_input_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during drain");

  // A drain always starts at channel zero
  a_drain_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_channel_index == '0))
    else $error("drain did not start at channel zero");

  // Channels advance by one on each non-final transfer
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && (out_channel_index == $past(out_channel_index) + 1'b1)))
    else $error("channel index did not step");

  // The drain ends right after the final channel is transferred
  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("output still valid after final channel");

endmodule
